FILE: rtl/gaq_pkg.sv
// Shared constants, codes and types of the group-aware queue.
// Used by the channel interfaces, the cell, the top level and the checker.
`timescale 1ns / 1ps

package gaq_pkg;

    // Queue geometry and payload widths.
    localparam int DEPTH      = 64;
    localparam int ID_BITS    = 16;
    localparam int GROUP_BITS = 8;

    // Command codes.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Contents of one queue cell.
    typedef struct packed {
        logic                  valid;
        logic [GROUP_BITS-1:0] group_tag;
        logic [ID_BITS-1:0]    member_id;
    } cell_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic                  enq;
        logic                  deq;
        logic                  any_match;
        logic [GROUP_BITS-1:0] group_tag;
        logic [ID_BITS-1:0]    member_id;
    } cell_ctrl_t;

endpackage

FILE: rtl/gaq_req_if.sv
// Request channel of the group-aware queue: valid, ready and the request fields.
// Depends on gaq_pkg.
`timescale 1ns / 1ps

interface gaq_req_if
    import gaq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [ID_BITS-1:0]    member_id;
    logic [GROUP_BITS-1:0] group_tag;

    modport source (output valid, output cmd, output member_id, output group_tag,
                    input ready);
    modport sink (input valid, input cmd, input member_id, input group_tag,
                  output ready);
endinterface

FILE: rtl/gaq_rsp_if.sv
// Response channel of the group-aware queue: valid, ready and the response fields.
// Depends on gaq_pkg.
`timescale 1ns / 1ps

interface gaq_rsp_if
    import gaq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] dequeued_id;
    logic [1:0]         status;

    modport source (output valid, output dequeued_id, output status, input ready);
    modport sink (input valid, input dequeued_id, input status, output ready);
endinterface

FILE: rtl/gaq_cell.sv
// One slot of the queue chain: holds an entry and moves it toward its neighbors.
// Depends on gaq_pkg.
`timescale 1ns / 1ps

module gaq_cell
    import gaq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_t      prev_cell,
    input  logic       prev_match,
    input  cell_t      next_cell,
    input  logic       rear_match,
    output cell_t      entry,
    output logic       own_match
);

    cell_t cell_reg;
    cell_t cell_next;
    logic  hit;

    // This cell holds an entry of the incoming group; the flag is OR-ed toward
    // the head so each cell knows whether a same-group entry sits at or behind it.
    assign hit       = cell_reg.valid && (cell_reg.group_tag == ctrl.group_tag);
    assign own_match = hit || rear_match;
    assign entry     = cell_reg;

    // Next contents: shift toward the head on dequeue; on enqueue keep, load the
    // new entry at the insertion slot, or shift back behind it.
    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.deq)
        begin
            cell_next = next_cell;
        end
        else if (ctrl.enq)
        begin
            priority if (own_match)
            begin
                cell_next = cell_reg;
            end
            else if (prev_match)
            begin
                cell_next = '{valid: 1'b1, group_tag: ctrl.group_tag,
                              member_id: ctrl.member_id};
            end
            else if (ctrl.any_match)
            begin
                cell_next = prev_cell;
            end
            else if (!cell_reg.valid && prev_cell.valid)
            begin
                cell_next = '{valid: 1'b1, group_tag: ctrl.group_tag,
                              member_id: ctrl.member_id};
            end
            else
            begin
                cell_next = cell_reg;
            end
        end
    end

    // The whole slot clears on reset, so the cell starts empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

FILE: rtl/group_aware_queue_top.sv
// Top level of the group-aware queue: the cell chain and the response register.
// Depends on gaq_pkg, gaq_req_if, gaq_rsp_if and gaq_cell.
`timescale 1ns / 1ps

// The group-aware queue keeps up to DEPTH (id, group) entries in a chain of
// cells with the head in cell 0. An enqueue request lands directly behind the
// last queued entry of its group, or at the tail when its group is absent; a
// dequeue request removes the head and returns its id. For every request, all
// cells compare their group with the request in parallel and shift in the
// same clock edge, so a new request is accepted every cycle as long as
// the response register is free or being drained. A successful enqueue gives
// no response; a dequeue gives one response (status ok or empty) and an
// enqueue on a full queue gives one with status full. The id is zero whenever
// the status is not ok. No clearing pass is needed after reset.
module group_aware_queue_top
    import gaq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gaq_req_if.sink   req,
    gaq_rsp_if.source rsp
);

    cell_t      cells [DEPTH];
    logic       match [DEPTH];
    cell_ctrl_t ctrl;
    logic       fire;
    logic       full;
    logic       empty;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic [ID_BITS-1:0] rsp_id_reg;
    logic [ID_BITS-1:0] rsp_id_next;
    logic [1:0]         rsp_status_reg;
    logic [1:0]         rsp_status_next;

    // Accept a request whenever the response register can take a result.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = cells[DEPTH-1].valid;
    assign empty     = !cells[0].valid;

    // Control broadcast to the chain.
    assign ctrl.enq       = fire && (req.cmd == CMD_ENQ) && !full;
    assign ctrl.deq       = fire && (req.cmd == CMD_DEQ) && !empty;
    assign ctrl.any_match = match[0];
    assign ctrl.group_tag = req.group_tag;
    assign ctrl.member_id = req.member_id;

    // The chain of cells, head first.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        cell_t prev_c;
        logic  prev_m;
        cell_t next_c;
        logic  next_m;

        if (k == 0)
        begin : g_head
            assign prev_c = '{valid: 1'b1, group_tag: '0, member_id: '0};
            assign prev_m = 1'b0;
        end
        else
        begin : g_body
            assign prev_c = cells[k-1];
            assign prev_m = match[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign next_c = '{valid: 1'b0, group_tag: '0, member_id: '0};
            assign next_m = 1'b0;
        end
        else
        begin : g_inner
            assign next_c = cells[k+1];
            assign next_m = match[k+1];
        end

        gaq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_cell  (prev_c),
            .prev_match (prev_m),
            .next_cell  (next_c),
            .rear_match (next_m),
            .entry      (cells[k]),
            .own_match  (match[k])
        );
    end

    // Response register: load a result when the request produces one, else
    // drop the held result once it is taken.
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_status_next = rsp_status_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (fire)
        begin
            if (req.cmd == CMD_DEQ)
            begin
                rsp_valid_next  = 1'b1;
                rsp_id_next     = empty ? '0 : cells[0].member_id;
                rsp_status_next = empty ? ST_EMPTY : ST_OK;
            end
            else if (full)
            begin
                rsp_valid_next  = 1'b1;
                rsp_id_next     = '0;
                rsp_status_next = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_id_reg     <= rsp_id_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.dequeued_id = rsp_id_reg;
    assign rsp.status      = rsp_status_reg;

endmodule

FILE: rtl/gaq_checker.sv
// Port-level checks of the group-aware queue, bound to the top level.
// Depends on gaq_pkg and group_aware_queue_top.
`timescale 1ns / 1ps

module gaq_checker
    import gaq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               req_cmd,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [ID_BITS-1:0] rsp_dequeued_id,
    input logic [1:0]         rsp_status
);

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dequeued_id)
                                    && $stable(rsp_status))
        else $error("response changed while stalled");

    // Only a stalled response may hold off requests.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request channel blocked without a stalled response");

    // Every accepted dequeue produces a response in the next cycle.
    a_deq_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == CMD_DEQ |=> rsp_valid)
        else $error("dequeue request gave no response");

    // Failure responses carry a zero id.
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_dequeued_id == '0)
        else $error("nonzero id on a failure response");

endmodule

bind group_aware_queue_top gaq_checker u_gaq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_cmd         (req.cmd),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_dequeued_id (rsp.dequeued_id),
    .rsp_status      (rsp.status)
);
